@@ rtl/core/slot_table_first_free_allocator_unit_assert.svh @@
// Assertion macros for the slot table allocator.
// Each macro expands to one concurrent assertion on clk, disabled while rst_n is low.
`ifndef SLOT_TABLE_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH
`define SLOT_TABLE_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/stfa_pkg.sv @@
// Shared constants, codes and payload types for the slot table allocator.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package stfa_pkg;

    localparam int FLOORS  = 5;
    localparam int SLOTS   = 8;
    localparam int ENTRIES = FLOORS * SLOTS;
    localparam int KEY_W   = 64;

    localparam int FL_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W = $clog2(2 * ENTRIES);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    localparam logic TBL_CAR  = 1'b0;
    localparam logic TBL_MOTO = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_DUP  = 2'd2,
        STATUS_MISS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_RES1,
        ST_RES2
    } state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic             table_sel;
        logic [KEY_W-1:0] entry_key;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic       which_table;
        logic [2:0] floor_index;
        logic [2:0] slot_index;
        logic       last_result;
    } rsp_t;

    // Key store address: car table first, motorcycle table after it.
    function automatic logic [ADDR_W-1:0] entry_addr(logic tbl, logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = tbl ? ADDR_W'(ENTRIES) : '0;
        return base + ADDR_W'(idx);
    endfunction

endpackage

@@ rtl/core/stfa_if.sv @@
// Valid/ready channels for requests and results of the slot table allocator.
// Depends on stfa_pkg for the payload types.
interface stfa_req_if;
    logic          valid;
    logic          ready;
    stfa_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stfa_rsp_if;
    logic          valid;
    logic          ready;
    stfa_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/stfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 80
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/slot_table_first_free_allocator_unit.sv @@
// Slot table allocator top level: sequencer, occupancy flags and key comparator.
// Depends on stfa_pkg, stfa_if, stfa_ram and the assertion macro header.
//
//  channel | dir | payload                                            | handshake
//  --------+-----+----------------------------------------------------+-------------
//  req     | in  | cmd, table_sel, entry_key                          | valid/ready
//  rsp     | out | status, which_table, floor_index, slot_index, last | valid/ready
//
// Insert and remove scan only the requested table; find scans both tables, car table
// first, and gives a second result when the key is in both. Each scan feeds the
// single 64-bit key comparator one key per cycle from the key RAM. req.ready is high
// only while idle; unused commands are dropped with no result. A stalled rsp holds
// the sequencer in its result state. Reset clears every occupied flag at once; the
// key RAM needs no clearing.
`include "slot_table_first_free_allocator_unit_assert.svh"

module slot_table_first_free_allocator_unit (
    input logic            clk,
    input logic            rst_n,
    stfa_req_if.sink       req,
    stfa_rsp_if.source     rsp
);

    localparam int FL_W   = stfa_pkg::FL_W;
    localparam int SL_W   = stfa_pkg::SL_W;
    localparam int IDX_W  = stfa_pkg::IDX_W;
    localparam int ADDR_W = stfa_pkg::ADDR_W;
    localparam int KEY_W  = stfa_pkg::KEY_W;
    localparam int ALL_E  = 2 * stfa_pkg::ENTRIES;

    stfa_pkg::state_t state_reg, state_next;

    // request held for the whole operation
    logic [1:0]       cmd_reg, cmd_next;
    logic             tbl_reg, tbl_next;
    logic [KEY_W-1:0] key_reg, key_next;

    // scan issue counters
    logic             scan_tbl_reg, scan_tbl_next;
    logic [FL_W-1:0]  iss_fl_reg, iss_fl_next;
    logic [SL_W-1:0]  iss_sl_reg, iss_sl_next;
    logic [IDX_W-1:0] iss_idx_reg, iss_idx_next;
    logic             iss_last;

    // compare stage, aligned with RAM read data
    logic             cmp_vld_reg, cmp_vld_next;
    logic             cmp_tbl_reg, cmp_tbl_next;
    logic             cmp_occ_reg, cmp_occ_next;
    logic [FL_W-1:0]  cmp_fl_reg, cmp_fl_next;
    logic [SL_W-1:0]  cmp_sl_reg, cmp_sl_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    // first match per table, first free of scanned table
    logic [1:0]       hit_reg, hit_next;
    logic [FL_W-1:0]  mfl_reg [2];
    logic [FL_W-1:0]  mfl_next [2];
    logic [SL_W-1:0]  msl_reg [2];
    logic [SL_W-1:0]  msl_next [2];
    logic [IDX_W-1:0] midx_reg [2];
    logic [IDX_W-1:0] midx_next [2];
    logic             free_hit_reg, free_hit_next;
    logic [FL_W-1:0]  free_fl_reg, free_fl_next;
    logic [SL_W-1:0]  free_sl_reg, free_sl_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic [ALL_E-1:0] occ_reg, occ_next;

    logic             rsp_vld_reg, rsp_vld_next;
    stfa_pkg::rsp_t   rsp_data_reg, rsp_data_next;
    logic             out_load;

    logic             req_cmd_ok;
    logic             ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic             ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [KEY_W-1:0] ram_rd_data;

    stfa_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ALL_E)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (key_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req.ready  = (state_reg == stfa_pkg::ST_IDLE);
    assign rsp.valid  = rsp_vld_reg;
    assign rsp.data   = rsp_data_reg;
    assign out_load   = !rsp_vld_reg || rsp.ready;
    assign iss_last   = (iss_fl_reg == FL_W'(stfa_pkg::FLOORS - 1)) &&
                        (iss_sl_reg == SL_W'(stfa_pkg::SLOTS - 1));
    assign req_cmd_ok = (req.data.cmd == stfa_pkg::CMD_INSERT) ||
                        (req.data.cmd == stfa_pkg::CMD_REMOVE) ||
                        (req.data.cmd == stfa_pkg::CMD_FIND);
    assign ram_rd_addr = stfa_pkg::entry_addr(scan_tbl_reg, iss_idx_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stfa_pkg::ST_IDLE:
            begin
                if (req.valid && req_cmd_ok)
                begin
                    state_next = stfa_pkg::ST_SCAN;
                end
            end
            stfa_pkg::ST_SCAN:
            begin
                if (iss_last)
                begin
                    state_next = stfa_pkg::ST_TAIL;
                end
            end
            stfa_pkg::ST_TAIL:
            begin
                if (cmd_reg == stfa_pkg::CMD_FIND && scan_tbl_reg == stfa_pkg::TBL_CAR)
                begin
                    state_next = stfa_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = stfa_pkg::ST_RES1;
                end
            end
            stfa_pkg::ST_RES1:
            begin
                if (out_load)
                begin
                    if (cmd_reg == stfa_pkg::CMD_FIND && hit_reg[0] && hit_reg[1])
                    begin
                        state_next = stfa_pkg::ST_RES2;
                    end
                    else
                    begin
                        state_next = stfa_pkg::ST_IDLE;
                    end
                end
            end
            stfa_pkg::ST_RES2:
            begin
                if (out_load)
                begin
                    state_next = stfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stfa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next      = cmd_reg;
        tbl_next      = tbl_reg;
        key_next      = key_reg;
        scan_tbl_next = scan_tbl_reg;
        iss_fl_next   = iss_fl_reg;
        iss_sl_next   = iss_sl_reg;
        iss_idx_next  = iss_idx_reg;
        hit_next      = hit_reg;
        mfl_next      = mfl_reg;
        msl_next      = msl_reg;
        midx_next     = midx_reg;
        free_hit_next = free_hit_reg;
        free_fl_next  = free_fl_reg;
        free_sl_next  = free_sl_reg;
        free_idx_next = free_idx_reg;
        occ_next      = occ_reg;
        rsp_data_next = rsp_data_reg;
        rsp_vld_next  = rsp_vld_reg && !rsp.ready;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = stfa_pkg::entry_addr(tbl_reg, free_idx_reg);
        ram_rd_en     = 1'b0;

        cmp_vld_next  = (state_reg == stfa_pkg::ST_SCAN);
        cmp_tbl_next  = scan_tbl_reg;
        cmp_occ_next  = occ_reg[ram_rd_addr];
        cmp_fl_next   = iss_fl_reg;
        cmp_sl_next   = iss_sl_reg;
        cmp_idx_next  = iss_idx_reg;

        // keep only the first hit and the first free entry in scan order
        if (cmp_vld_reg)
        begin
            if (cmp_occ_reg && ram_rd_data == key_reg && !hit_reg[cmp_tbl_reg])
            begin
                hit_next[cmp_tbl_reg]  = 1'b1;
                mfl_next[cmp_tbl_reg]  = cmp_fl_reg;
                msl_next[cmp_tbl_reg]  = cmp_sl_reg;
                midx_next[cmp_tbl_reg] = cmp_idx_reg;
            end
            if (!cmp_occ_reg && !free_hit_reg)
            begin
                free_hit_next = 1'b1;
                free_fl_next  = cmp_fl_reg;
                free_sl_next  = cmp_sl_reg;
                free_idx_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            stfa_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = req.data.cmd;
                    tbl_next      = req.data.table_sel;
                    key_next      = req.data.entry_key;
                    scan_tbl_next = (req.data.cmd == stfa_pkg::CMD_FIND) ?
                                    stfa_pkg::TBL_CAR : req.data.table_sel;
                    iss_fl_next   = '0;
                    iss_sl_next   = '0;
                    iss_idx_next  = '0;
                    hit_next      = '0;
                    free_hit_next = 1'b0;
                end
            end
            stfa_pkg::ST_SCAN:
            begin
                ram_rd_en = 1'b1;
                // advance floor-major; wraps to zero after the last entry
                if (iss_last)
                begin
                    iss_fl_next  = '0;
                    iss_sl_next  = '0;
                    iss_idx_next = '0;
                end
                else if (iss_sl_reg == SL_W'(stfa_pkg::SLOTS - 1))
                begin
                    iss_fl_next  = iss_fl_reg + 1'b1;
                    iss_sl_next  = '0;
                    iss_idx_next = iss_idx_reg + 1'b1;
                end
                else
                begin
                    iss_sl_next  = iss_sl_reg + 1'b1;
                    iss_idx_next = iss_idx_reg + 1'b1;
                end
            end
            stfa_pkg::ST_TAIL:
            begin
                if (cmd_reg == stfa_pkg::CMD_FIND)
                begin
                    scan_tbl_next = stfa_pkg::TBL_MOTO;
                end
            end
            stfa_pkg::ST_RES1:
            begin
                if (out_load)
                begin
                    rsp_vld_next              = 1'b1;
                    rsp_data_next.which_table = tbl_reg;
                    rsp_data_next.floor_index = '0;
                    rsp_data_next.slot_index  = '0;
                    rsp_data_next.last_result = 1'b1;
                    if (cmd_reg == stfa_pkg::CMD_INSERT)
                    begin
                        if (!free_hit_reg)
                        begin
                            rsp_data_next.status = stfa_pkg::STATUS_FULL;
                        end
                        else if (hit_reg[tbl_reg])
                        begin
                            rsp_data_next.status = stfa_pkg::STATUS_DUP;
                        end
                        else
                        begin
                            rsp_data_next.status      = stfa_pkg::STATUS_OK;
                            rsp_data_next.floor_index = 3'(free_fl_reg);
                            rsp_data_next.slot_index  = 3'(free_sl_reg);
                            ram_wr_en                 = 1'b1;
                            occ_next[ram_wr_addr]     = 1'b1;
                        end
                    end
                    else if (cmd_reg == stfa_pkg::CMD_REMOVE)
                    begin
                        if (hit_reg[tbl_reg])
                        begin
                            rsp_data_next.status      = stfa_pkg::STATUS_OK;
                            rsp_data_next.floor_index = 3'(mfl_reg[tbl_reg]);
                            rsp_data_next.slot_index  = 3'(msl_reg[tbl_reg]);
                            occ_next[stfa_pkg::entry_addr(tbl_reg, midx_reg[tbl_reg])] = 1'b0;
                        end
                        else
                        begin
                            rsp_data_next.status = stfa_pkg::STATUS_MISS;
                        end
                    end
                    else
                    begin
                        // find: car table first, then motorcycle table
                        if (hit_reg[0])
                        begin
                            rsp_data_next.status      = stfa_pkg::STATUS_OK;
                            rsp_data_next.which_table = stfa_pkg::TBL_CAR;
                            rsp_data_next.floor_index = 3'(mfl_reg[0]);
                            rsp_data_next.slot_index  = 3'(msl_reg[0]);
                            rsp_data_next.last_result = !hit_reg[1];
                        end
                        else if (hit_reg[1])
                        begin
                            rsp_data_next.status      = stfa_pkg::STATUS_OK;
                            rsp_data_next.which_table = stfa_pkg::TBL_MOTO;
                            rsp_data_next.floor_index = 3'(mfl_reg[1]);
                            rsp_data_next.slot_index  = 3'(msl_reg[1]);
                        end
                        else
                        begin
                            rsp_data_next.status      = stfa_pkg::STATUS_MISS;
                            rsp_data_next.which_table = stfa_pkg::TBL_CAR;
                        end
                    end
                end
            end
            stfa_pkg::ST_RES2:
            begin
                if (out_load)
                begin
                    rsp_vld_next              = 1'b1;
                    rsp_data_next.status      = stfa_pkg::STATUS_OK;
                    rsp_data_next.which_table = stfa_pkg::TBL_MOTO;
                    rsp_data_next.floor_index = 3'(mfl_reg[1]);
                    rsp_data_next.slot_index  = 3'(msl_reg[1]);
                    rsp_data_next.last_result = 1'b1;
                end
            end
            default:
            begin
                rsp_vld_next = rsp_vld_reg && !rsp.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stfa_pkg::ST_IDLE;
            hit_reg      <= '0;
            free_hit_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            occ_reg      <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hit_reg      <= hit_next;
            free_hit_reg <= free_hit_next;
            cmp_vld_reg  <= cmp_vld_next;
            occ_reg      <= occ_next;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tbl_reg      <= tbl_next;
        key_reg      <= key_next;
        scan_tbl_reg <= scan_tbl_next;
        iss_fl_reg   <= iss_fl_next;
        iss_sl_reg   <= iss_sl_next;
        iss_idx_reg  <= iss_idx_next;
        cmp_tbl_reg  <= cmp_tbl_next;
        cmp_occ_reg  <= cmp_occ_next;
        cmp_fl_reg   <= cmp_fl_next;
        cmp_sl_reg   <= cmp_sl_next;
        cmp_idx_reg  <= cmp_idx_next;
        mfl_reg      <= mfl_next;
        msl_reg      <= msl_next;
        midx_reg     <= midx_next;
        free_fl_reg  <= free_fl_next;
        free_sl_reg  <= free_sl_next;
        free_idx_reg <= free_idx_next;
        rsp_data_reg <= rsp_data_next;
    end

    `STFA_ASSERT_NEXT(a_insert_marks_occupied, ram_wr_en, occ_reg[$past(ram_wr_addr)], "inserted entry not marked occupied")
    `STFA_ASSERT_NOW(a_cmp_only_in_scan, cmp_vld_reg, state_reg == stfa_pkg::ST_SCAN || state_reg == stfa_pkg::ST_TAIL, "compare stage active outside scan")
    `STFA_ASSERT_NOW(a_second_result_needs_two_hits, state_reg == stfa_pkg::ST_RES2, hit_reg[0] && hit_reg[1] && cmd_reg == stfa_pkg::CMD_FIND, "second result without hits in both tables")
    `STFA_ASSERT_NOW(a_scan_counters_in_range, state_reg == stfa_pkg::ST_SCAN, iss_fl_reg <= FL_W'(stfa_pkg::FLOORS - 1) && iss_sl_reg <= SL_W'(stfa_pkg::SLOTS - 1), "scan counters out of range")

endmodule
